// ----- hdl/tbte_pkg.sv -----
// Shared types, constants and coefficient tables for the type B thermocouple EMF block.
package tbte_pkg;

  localparam int IN_W     = 22;
  localparam int T_W      = 21;
  localparam int EMF_W    = 19;
  localparam int ACC_W    = 50;
  localparam int COEF_W   = 44;
  localparam int PROD_W   = 64;
  localparam int LO_W     = 25;
  localparam int HI_W     = ACC_W - LO_W;
  localparam int PP_W     = LO_W + T_W;
  localparam int E_W      = 3;
  localparam int REM_W    = 17;
  localparam int HALF_W   = 23;
  localparam int K_W      = 4;
  localparam int DIV_BITS = 8;
  localparam int DIV_CYCLES = PROD_W / DIV_BITS;
  localparam int CNT_W    = $clog2(DIV_CYCLES);

  localparam logic [T_W-1:0] T_MAX   = 21'd1820000;
  localparam logic [T_W-1:0] T_SPLIT = 21'd630615;
  localparam logic [K_W-1:0] DEG_LO  = 4'd6;
  localparam logic [K_W-1:0] DEG_HI  = 4'd8;
  localparam logic [E_W-1:0] FIN_EXP = 3'd7;

  localparam logic [PROD_W-1:0] EMF_NEG_LIM = 64'd100;
  localparam logic [PROD_W-1:0] EMF_POS_LIM = 64'd140000;
  localparam logic signed [EMF_W-1:0] EMF_MIN = -19'sd100;
  localparam logic signed [EMF_W-1:0] EMF_MAX = 19'sd140000;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_MSTART,
    SQ_MWAIT,
    SQ_DWAIT,
    SQ_FSTART,
    SQ_FWAIT,
    SQ_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    MP_IDLE,
    MP_LO,
    MP_HI,
    MP_SUM
  } mul_phase_t;

  typedef enum logic {
    DV_IDLE,
    DV_RUN
  } div_state_t;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] mag;
    logic [T_W-1:0]   t;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] mag;
    logic [E_W-1:0]    e;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [COEF_W-1:0] coef_rom(input logic hi,
                                                        input logic [K_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (hi) begin
      case (idx)
        4'd0:    c = -44'sd389381686210;
        4'd1:    c = 44'sd2857174747000;
        4'd2:    c = -44'sd848851047850;
        4'd3:    c = 44'sd1578528016400;
        4'd4:    c = -44'sd1683534486400;
        4'd5:    c = 44'sd1110979401300;
        4'd6:    c = -44'sd445154310330;
        4'd7:    c = 44'sd989756408210;
        4'd8:    c = -44'sd937913302890;
        default: c = '0;
      endcase
    end else begin
      case (idx)
        4'd1:    c = -44'sd246508183460;
        4'd2:    c = 44'sd590404211710;
        4'd3:    c = -44'sd1325793163600;
        4'd4:    c = 44'sd1566829190100;
        4'd5:    c = -44'sd1694452924000;
        4'd6:    c = 44'sd629903470940;
        default: c = '0;
      endcase
    end
    return c;
  endfunction

  function automatic logic [E_W-1:0] shift_rom(input logic hi, input logic [K_W-1:0] idx);
    logic [E_W-1:0] s;
    s = 3'd6;
    if (hi) begin
      case (idx)
        4'd0:    s = 3'd6;
        4'd1:    s = 3'd5;
        4'd6:    s = 3'd7;
        4'd7:    s = 3'd7;
        default: s = 3'd6;
      endcase
    end else begin
      case (idx)
        4'd0:    s = 3'd7;
        4'd1:    s = 3'd5;
        4'd2:    s = 3'd7;
        default: s = 3'd6;
      endcase
    end
    return s;
  endfunction

  function automatic logic [REM_W-1:0] pow5_rom(input logic [E_W-1:0] e);
    logic [REM_W-1:0] p;
    unique case (e)
      3'd0: p = 17'd1;
      3'd1: p = 17'd5;
      3'd2: p = 17'd25;
      3'd3: p = 17'd125;
      3'd4: p = 17'd625;
      3'd5: p = 17'd3125;
      3'd6: p = 17'd15625;
      3'd7: p = 17'd78125;
    endcase
    return p;
  endfunction

  function automatic logic [HALF_W-1:0] half_rom(input logic [E_W-1:0] e);
    logic [HALF_W-1:0] h;
    unique case (e)
      3'd0: h = 23'd0;
      3'd1: h = 23'd5;
      3'd2: h = 23'd50;
      3'd3: h = 23'd500;
      3'd4: h = 23'd5000;
      3'd5: h = 23'd50000;
      3'd6: h = 23'd500000;
      3'd7: h = 23'd5000000;
    endcase
    return h;
  endfunction

endpackage

// ----- hdl/tbte_mul.sv -----
// Magnitude times temperature on one shared partial-product multiplier: low half, high half, sum.
module tbte_mul import tbte_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  mul_phase_t phase, phase_next;

  logic [ACC_W-1:0]    a;
  logic [T_W-1:0]      t;
  logic [PP_W-1:0]     p_lo;
  logic [PP_W-1:0]     p_hi;
  logic [LO_W-1:0]     op;
  logic [PP_W-1:0]     mult;
  logic [HI_W+PP_W-1:0] sum;
  logic [PROD_W-1:0]   prod;
  logic                done;

  assign op   = (phase == MP_LO) ? a[LO_W-1:0] : LO_W'(a[ACC_W-1:LO_W]);
  assign mult = op * t;
  assign sum  = {p_hi, {LO_W{1'b0}}} + (HI_W+PP_W)'(p_lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= MP_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == MP_SUM);
    end
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      MP_IDLE: if (req.start) phase_next = MP_LO;
      MP_LO:   phase_next = MP_HI;
      MP_HI:   phase_next = MP_SUM;
      MP_SUM:  phase_next = MP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (phase == MP_IDLE && req.start) begin
      a <= req.mag;
      t <= req.t;
    end
    if (phase == MP_LO) p_lo <= mult;
    if (phase == MP_HI) p_hi <= mult;
    if (phase == MP_SUM) prod <= sum[PROD_W-1:0];
  end

  assign rsp.done = done;
  assign rsp.prod = prod;

endmodule

// ----- hdl/tbte_div.sv -----
// Round-half-up division by a power of ten, eight quotient bits per cycle.
module tbte_div import tbte_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  div_state_t state, state_next;

  logic [CNT_W-1:0]  cnt;
  logic [PROD_W-1:0] quo;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  dvs;
  logic              done;
  logic [PROD_W:0]   biased;
  logic [PROD_W:0]   scaled;
  logic [PROD_W-1:0] quo_next;
  logic [REM_W-1:0]  rem_next;
  logic [PROD_W-1:0] y;
  logic [REM_W-1:0]  r;
  logic [REM_W:0]    trial;

  assign biased = {1'b0, req.mag} + (PROD_W+1)'(half_rom(req.e));
  assign scaled = biased >> req.e;

  always_comb begin
    r = rem;
    y = quo;
    trial = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {r, y[PROD_W-1]};
      y = {y[PROD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        r = REM_W'(trial - {1'b0, dvs});
        y[0] = 1'b1;
      end else begin
        r = trial[REM_W-1:0];
      end
    end
    quo_next = y;
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == DV_RUN) && (cnt == CNT_W'(DIV_CYCLES - 1));
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      DV_IDLE: if (req.start) state_next = DV_RUN;
      DV_RUN:  if (cnt == CNT_W'(DIV_CYCLES - 1)) state_next = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == DV_IDLE && req.start) begin
      quo <= scaled[PROD_W-1:0];
      rem <= '0;
      dvs <= pow5_rom(req.e);
      cnt <= '0;
    end else if (state == DV_RUN) begin
      quo <= quo_next;
      rem <= rem_next;
      cnt <= cnt + 1'b1;
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

// ----- hdl/type_b_thermocouple_temp_to_emf_top.sv -----
// Type B thermocouple EMF from temperature: Horner sequencer around shared multiply and divide.
// Out of range skips the arithmetic; degree 6 below 630.615 degC, degree 8 at or above.
// Each Horner step runs the shared multiplier (low product, high product, sum), then the divider
// (a load, then passes of 8 quotient bits); final rounding is one more division.
// Throughput: one request at a time; a new one is taken once the result is in the output register.
// Reset: synchronous, active high; clears the sequencer and the output valid.
module type_b_thermocouple_temp_to_emf_top import tbte_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    temp_valid,
  output logic                    temp_ready,
  input  logic signed [IN_W-1:0]  temp_milli_c,
  output logic                    emf_valid,
  input  logic                    emf_ready,
  output logic signed [EMF_W-1:0] emf_tenth_uv,
  output logic                    in_range
);

  seq_state_t state, state_next;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [ACC_W-1:0] acc;
  logic [ACC_W-1:0]        acc_mag;
  logic [K_W-1:0]          k;
  logic [K_W-1:0]          km1;
  logic [T_W-1:0]          t_mag;
  logic                    hi;
  logic signed [EMF_W-1:0] res_emf;
  logic                    res_ok;

  logic                    t_ok;
  logic                    t_hi;
  logic [K_W-1:0]          deg;
  logic [PROD_W-1:0]       coef_ext;
  logic [PROD_W-1:0]       step_sum;
  logic signed [EMF_W-1:0] emf_clamp;
  logic                    out_load;

  assign t_ok = !temp_milli_c[IN_W-1] && (temp_milli_c[T_W-1:0] <= T_MAX);
  assign t_hi = temp_milli_c[T_W-1:0] >= T_SPLIT;
  assign deg  = t_hi ? DEG_HI : DEG_LO;

  assign acc_mag  = acc[ACC_W-1] ? (ACC_W'(0) - acc) : acc;
  assign km1      = k - 1'b1;
  assign coef_ext = PROD_W'(coef_rom(hi, km1));
  assign step_sum = acc[ACC_W-1] ? (coef_ext - div_rsp.quo) : (coef_ext + div_rsp.quo);
  assign out_load = (state == SQ_OUT) && (!emf_valid || emf_ready);

  always_comb begin
    if (acc[ACC_W-1]) begin
      if (div_rsp.quo > EMF_NEG_LIM) emf_clamp = EMF_MIN;
      else emf_clamp = EMF_W'(0) - div_rsp.quo[EMF_W-1:0];
    end else begin
      if (div_rsp.quo > EMF_POS_LIM) emf_clamp = EMF_MAX;
      else emf_clamp = div_rsp.quo[EMF_W-1:0];
    end
  end

  tbte_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  tbte_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    temp_ready = 1'b0;
    mul_req    = '0;
    div_req    = '0;
    unique case (state)
      SQ_IDLE: begin
        temp_ready = 1'b1;
        if (temp_valid) state_next = t_ok ? SQ_MSTART : SQ_OUT;
      end
      SQ_MSTART: begin
        mul_req.start = 1'b1;
        mul_req.mag   = acc_mag;
        mul_req.t     = t_mag;
        state_next    = SQ_MWAIT;
      end
      SQ_MWAIT: begin
        div_req.mag = mul_rsp.prod;
        div_req.e   = shift_rom(hi, km1);
        if (mul_rsp.done) begin
          div_req.start = 1'b1;
          state_next    = SQ_DWAIT;
        end
      end
      SQ_DWAIT: begin
        if (div_rsp.done) state_next = (k == K_W'(1)) ? SQ_FSTART : SQ_MSTART;
      end
      SQ_FSTART: begin
        div_req.start = 1'b1;
        div_req.mag   = PROD_W'(acc_mag);
        div_req.e     = FIN_EXP;
        state_next    = SQ_FWAIT;
      end
      SQ_FWAIT: begin
        if (div_rsp.done) state_next = SQ_OUT;
      end
      SQ_OUT: begin
        if (!emf_valid || emf_ready) state_next = SQ_IDLE;
      end
      default: state_next = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == SQ_IDLE && temp_valid) begin
      t_mag   <= temp_milli_c[T_W-1:0];
      hi      <= t_hi;
      k       <= deg;
      acc     <= ACC_W'(coef_rom(t_hi, deg));
      res_emf <= '0;
      res_ok  <= t_ok;
    end
    if (state == SQ_DWAIT && div_rsp.done) begin
      acc <= step_sum[ACC_W-1:0];
      k   <= km1;
    end
    if (state == SQ_FWAIT && div_rsp.done) begin
      res_emf <= emf_clamp;
    end
    if (out_load) begin
      emf_tenth_uv <= res_emf;
      in_range     <= res_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emf_valid <= 1'b0;
    end else if (out_load) begin
      emf_valid <= 1'b1;
    end else if (emf_ready) begin
      emf_valid <= 1'b0;
    end
  end

endmodule

// ----- dv/tb.sv -----
// Testbench for the type B thermocouple EMF block: directed and random requests vs a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tbte_pkg::*;

  typedef struct {
    logic signed [EMF_W-1:0] emf;
    logic                    in_range;
  } emf_result_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE
  } ready_mode_t;

  localparam int DIRECTED_N = 20;
  localparam int RANDOM_N   = 1530;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    temp_valid = 1'b0;
  logic                    temp_ready;
  logic signed [IN_W-1:0]  temp_milli_c = '0;
  logic                    emf_valid;
  logic                    emf_ready = 1'b0;
  logic signed [EMF_W-1:0] emf_tenth_uv;
  logic                    in_range;

  logic signed [IN_W-1:0] temp_pending_q[$];
  emf_result_t            emf_due_q[$];
  int                     errors = 0;
  int                     results_seen = 0;
  int                     burst_left = 1;
  int                     gap_left = 0;
  int                     hold_left = 0;
  int                     holds_done = 0;
  int                     mode_left = 0;
  ready_mode_t            ready_mode = READY_ALWAYS;

  type_b_thermocouple_temp_to_emf_top dut (
    .clk          (clk),
    .rst          (rst),
    .temp_valid   (temp_valid),
    .temp_ready   (temp_ready),
    .temp_milli_c (temp_milli_c),
    .emf_valid    (emf_valid),
    .emf_ready    (emf_ready),
    .emf_tenth_uv (emf_tenth_uv),
    .in_range     (in_range)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint poly_coef(bit upper, int k);
    longint c;
    c = 0;
    if (upper) begin
      case (k)
        0: c = -64'sd389381686210;
        1: c = 64'sd2857174747000;
        2: c = -64'sd848851047850;
        3: c = 64'sd1578528016400;
        4: c = -64'sd1683534486400;
        5: c = 64'sd1110979401300;
        6: c = -64'sd445154310330;
        7: c = 64'sd989756408210;
        8: c = -64'sd937913302890;
        default: c = 0;
      endcase
    end else begin
      case (k)
        1: c = -64'sd246508183460;
        2: c = 64'sd590404211710;
        3: c = -64'sd1325793163600;
        4: c = 64'sd1566829190100;
        5: c = -64'sd1694452924000;
        6: c = 64'sd629903470940;
        default: c = 0;
      endcase
    end
    return c;
  endfunction

  function automatic int poly_scale(bit upper, int k);
    int s;
    s = 6;
    if (upper) begin
      if (k == 1) s = 5;
      else if (k >= 6) s = 7;
    end else begin
      if (k == 0 || k == 2) s = 7;
      else if (k == 1) s = 5;
    end
    return s;
  endfunction

  function automatic bit [63:0] abs64(longint a);
    return (a < 0) ? 64'(-a) : 64'(a);
  endfunction

  function automatic longint div_pow10_round(bit [63:0] mag, bit neg, int e);
    bit [63:0] d;
    bit [63:0] q;
    d = 64'd1;
    repeat (e) d = d * 64'd10;
    q = mag / d;
    if (mag % d >= d - d / 64'd2) q = q + 64'd1;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic emf_result_t emf_of_temp(logic signed [IN_W-1:0] temp);
    emf_result_t r;
    longint      t;
    longint      acc;
    longint      emf;
    bit          upper;
    int          deg;
    t = longint'(temp);
    r.emf = '0;
    r.in_range = 1'b0;
    if (t >= 0 && t <= longint'(T_MAX)) begin
      upper = (t >= longint'(T_SPLIT));
      deg = upper ? 8 : 6;
      acc = poly_coef(upper, deg);
      for (int k = deg - 1; k >= 0; k--) begin
        acc = div_pow10_round(abs64(acc) * 64'(t), acc < 0, poly_scale(upper, k))
              + poly_coef(upper, k);
      end
      emf = div_pow10_round(abs64(acc), acc < 0, 7);
      if (emf < -100) emf = -100;
      if (emf > 140000) emf = 140000;
      r.emf = EMF_W'(emf);
      r.in_range = 1'b1;
    end
    return r;
  endfunction

  // driver: bursts of requests with random gaps
  always @(posedge clk) begin
    if (rst) begin
      temp_valid <= 1'b0;
    end else begin
      if (temp_valid && temp_ready) emf_due_q.push_back(emf_of_temp(temp_milli_c));
      if (!temp_valid || temp_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          temp_valid <= 1'b0;
        end else if (temp_pending_q.size() > 0) begin
          temp_milli_c <= temp_pending_q.pop_front();
          temp_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 150)
                                                    : $urandom_range(0, 8);
          end
        end else begin
          temp_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with long hold-offs to back up the block
  always @(posedge clk) begin
    if (rst) begin
      emf_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      emf_ready <= 1'b0;
    end else if ((holds_done == 0 && results_seen >= 300) ||
                 (holds_done == 1 && results_seen >= 1000)) begin
      holds_done++;
      hold_left = 800;
      emf_ready <= 1'b0;
    end else begin
      if (mode_left <= 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 400);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        READY_ALWAYS: emf_ready <= 1'b1;
        READY_HALF:   emf_ready <= 1'($urandom_range(0, 1));
        default:      emf_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    emf_result_t want;
    if (!rst && emf_valid && emf_ready) begin
      results_seen++;
      if (emf_due_q.size() == 0) begin
        $error("unexpected result: emf_tenth_uv %0d in_range %0b", emf_tenth_uv, in_range);
        errors++;
      end else begin
        want = emf_due_q.pop_front();
        if (emf_tenth_uv !== want.emf) begin
          $error("emf_tenth_uv: expected %0d, got %0d", want.emf, emf_tenth_uv);
          errors++;
        end
        if (in_range !== want.in_range) begin
          $error("in_range: expected %0b, got %0b", want.in_range, in_range);
          errors++;
        end
      end
    end
  end

  initial begin
    int pick;
    int centre;
    logic signed [IN_W-1:0] directed [DIRECTED_N];
    directed = '{-22'sd2097152, -22'sd2000000, -22'sd1, 22'sd0, 22'sd1, 22'sd2, 22'sd500,
                 22'sd100000, 22'sd630614, 22'sd630615, 22'sd630616, 22'sd1000000,
                 22'sd1500000, 22'sd1819999, 22'sd1820000, 22'sd1820001, 22'sd2000000,
                 22'sd2097151, 22'sd1398101, -22'sd1398102};
    foreach (directed[i]) temp_pending_q.push_back(directed[i]);
    for (int i = 0; i < RANDOM_N; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        temp_pending_q.push_back(IN_W'($urandom_range(0, int'(T_MAX))));
      end else if (pick < 88) begin
        case ($urandom_range(0, 2))
          0:       centre = 0;
          1:       centre = int'(T_SPLIT);
          default: centre = int'(T_MAX);
        endcase
        temp_pending_q.push_back(IN_W'(centre + $urandom_range(0, 100) - 50));
      end else begin
        temp_pending_q.push_back(IN_W'($urandom_range(0, 32'h3FFFFF)));
      end
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (temp_pending_q.size() > 0 || temp_valid || emf_due_q.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("type_b_thermocouple_temp_to_emf_top: match");
    end else begin
      $display("type_b_thermocouple_temp_to_emf_top: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("type_b_thermocouple_temp_to_emf_top: mismatch");
    $finish;
  end

endmodule

// ----- type_b_thermocouple_temp_to_emf_top.f -----
hdl/tbte_pkg.sv
hdl/tbte_mul.sv
hdl/tbte_div.sv
hdl/type_b_thermocouple_temp_to_emf_top.sv
dv/tb.sv
